// ----- hw/rtl/smer_pkg.sv -----
// Package for the stereo early-reflection block: sizes, register indexes,
// control structs and fixed-point constants. No dependencies.
`default_nettype none

package smer_pkg;

   // history store and tap count
   localparam int DELAY_DEPTH = 2048;
   localparam int NUM_TAPS    = 4;
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);
   localparam int FILL_W      = ADDR_W + 1;
   localparam int TAP_W       = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

   // fixed field widths
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 17;
   localparam int DELAY_W   = 16;
   localparam int SIGN_R_OFS = 4;
   localparam int MULT_W    = SAMPLE_W + GAIN_W + 1;
   localparam int PROD_W    = MULT_W - 1;
   localparam int ACC_W     = PROD_W + 2;
   localparam int SCALED_W  = ACC_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 28;
   localparam int RQ_W      = SCALED_W - ROUND_SHIFT;

   localparam logic [GAIN_W-1:0]  GAIN_MAX  = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(16384);
   localparam logic [DELAY_W:0]   DELAY_MAX = (DELAY_W + 1)'(DELAY_DEPTH - 1);
   localparam logic signed [SCALED_W-1:0] ROUND_BIAS = SCALED_W'(64'd1 << (ROUND_SHIFT - 1));
   localparam logic signed [RQ_W-1:0] SAT_HI = RQ_W'(32767);
   localparam logic signed [RQ_W-1:0] SAT_LO = -RQ_W'(32768);

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAYS_01 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAYS_23 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_0  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_1  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_2  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_3  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNS     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL     = 4'd7;

   // sequencer to lane
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic              clear;
      logic              hit;
      logic [ADDR_W-1:0] addr;
      logic [GAIN_W-1:0] weight;
   } lane_ctrl_type;

   // sequencer to merge stage
   typedef struct packed {
      logic scale_en;
      logic load;
   } merge_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/smer_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module smer_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/smer_lane.sv -----
// One channel lane: history store plus tap multiply-accumulate.
// Depends on smer_pkg and smer_ram.
`default_nettype none

module smer_lane
   import smer_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lane_ctrl_type              ctrl,
   input  wire logic                       neg,
   input  wire logic signed [SAMPLE_W-1:0] wr_sample,
   output logic signed [ACC_W-1:0]         acc
);

   logic [SAMPLE_W-1:0]        rd_data;
   logic                       s1_valid_ff;
   logic                       s1_hit_ff;
   logic                       s1_neg_ff;
   logic [GAIN_W-1:0]          s1_weight_ff;
   logic                       s2_valid_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [MULT_W-1:0]   mult;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;

   smer_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .rd_en   (ctrl.rd_en),
      .addr    (ctrl.addr),
      .wr_data (wr_sample),
      .rd_data (rd_data)
   );

   // entries not yet written since reset read as zero
   always_comb begin
      sample  = s1_hit_ff ? $signed(rd_data) : '0;
      mult    = sample * $signed({1'b0, s1_weight_ff});
      prod_in = s1_neg_ff ? -mult[PROD_W-1:0] : mult[PROD_W-1:0];
      acc_in  = acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_hit_ff    <= ctrl.hit;
      s1_neg_ff    <= neg;
      s1_weight_ff <= ctrl.weight;
      prod_ff      <= prod_in;
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/smer_merge.sv -----
// Merge stage: scales both lane sums by the level, rounds and saturates.
// Depends on smer_pkg.
`default_nettype none

module smer_merge
   import smer_pkg::*;
(
   input  wire logic                       clock,
   input  wire merge_ctrl_type             ctrl,
   input  wire logic [GAIN_W-1:0]          level,
   input  wire logic signed [ACC_W-1:0]    acc_left,
   input  wire logic signed [ACC_W-1:0]    acc_right,
   output logic signed [SAMPLE_W-1:0]      left_out,
   output logic signed [SAMPLE_W-1:0]      right_out
);

   logic signed [SCALED_W-1:0] scaled_l_ff;
   logic signed [SCALED_W-1:0] scaled_r_ff;
   logic signed [SAMPLE_W-1:0] left_out_ff;
   logic signed [SAMPLE_W-1:0] right_out_ff;

   // round half up at bit 28, then clip to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [SCALED_W-1:0] v
   );
      logic signed [SCALED_W-1:0] biased;
      logic signed [RQ_W-1:0]     rq;
      biased = v + ROUND_BIAS;
      rq     = biased[SCALED_W-1:ROUND_SHIFT];
      if (rq > SAT_HI) begin
         return SAT_HI[SAMPLE_W-1:0];
      end else if (rq < SAT_LO) begin
         return SAT_LO[SAMPLE_W-1:0];
      end
      return rq[SAMPLE_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ctrl.scale_en) begin
         scaled_l_ff <= acc_left * $signed({1'b0, level});
         scaled_r_ff <= acc_right * $signed({1'b0, level});
      end
      if (ctrl.load) begin
         left_out_ff  <= round_sat(scaled_l_ff);
         right_out_ff <= round_sat(scaled_r_ff);
      end
   end

   assign left_out  = left_out_ff;
   assign right_out = right_out_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_multitap_early_reflections.sv -----
// Top level of the stereo multitap early-reflection block: control registers,
// tap sequencer, two channel lanes and the merge stage.
// Depends on smer_pkg, smer_lane, smer_merge.
//
//   channel | ports                              | direction | transfer when
//   --------+------------------------------------+-----------+-------------------------
//   req     | req_valid/ready, req_left/right_in | in        | req_valid && req_ready
//   rsp     | rsp_valid/ready, rsp_left/right_out| out       | rsp_valid && rsp_ready
//   csr     | csr_valid/ready, csr_index, data   | in        | csr_valid (ready tied high)
//
// A new item is taken only once the last has left the output step. Each item
// has a write step, one tap read per cycle from each side's single-port history
// store, a multiply-accumulate drain, a level multiply and a round/saturate step.
// Synchronous active-high reset; no clearing pass: a fill count marks which
// store entries have been written, unwritten entries read as zero.
// A finished result waits in the output register; a held rsp stalls the
// sequencer at its last step only.
`default_nettype none

module stereo_multitap_early_reflections
   import smer_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input samples
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_left_in,
   input  wire logic signed [SAMPLE_W-1:0] req_right_in,
   // results
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_left_out,
   output logic signed [SAMPLE_W-1:0]      rsp_right_out,
   // configuration writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_TAPS,
      ST_DRAIN,
      ST_SCALE,
      ST_OUT
   } state_type;

   state_type state_ff;

   // control registers, kept raw; clamping happens on use
   logic [2*DELAY_W-1:0] delays01_ff;
   logic [2*DELAY_W-1:0] delays23_ff;
   logic [GAIN_W-1:0]    weight_ff [4];
   logic [7:0]           signs_ff;
   logic [GAIN_W-1:0]    level_ff;

   logic [ADDR_W-1:0]          wp_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic [TAP_W-1:0]           tap_ff;
   logic                       drain_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] left_ff;
   logic signed [SAMPLE_W-1:0] right_ff;

   logic [4*DELAY_W-1:0] delay_word;
   logic [ADDR_W-1:0]    tap_delay [NUM_TAPS];
   logic [GAIN_W-1:0]    tap_weight [NUM_TAPS];
   logic                 tap_neg_l [NUM_TAPS];
   logic                 tap_neg_r [NUM_TAPS];

   logic [ADDR_W:0]          rd_diff;
   logic [ADDR_W-1:0]        rd_addr;
   logic [GAIN_W-1:0]        level_eff;
   logic                     out_go;
   lane_ctrl_type            lane_ctrl;
   merge_ctrl_type           merge_ctrl;
   logic signed [ACC_W-1:0]  acc_l;
   logic signed [ACC_W-1:0]  acc_r;

   // per-tap delay, weight and sign, clamped
   assign delay_word = {delays23_ff, delays01_ff};

   for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
      logic [DELAY_W-1:0] raw;
      assign raw           = delay_word[DELAY_W*t +: DELAY_W];
      assign tap_delay[t]  = ({1'b0, raw} > DELAY_MAX) ? DELAY_MAX[ADDR_W-1:0]
                                                       : raw[ADDR_W-1:0];
      assign tap_weight[t] = (weight_ff[t] > GAIN_MAX) ? GAIN_MAX : weight_ff[t];
      assign tap_neg_l[t]  = signs_ff[t];
      assign tap_neg_r[t]  = signs_ff[SIGN_R_OFS + t];
   end

   assign level_eff = (level_ff > GAIN_MAX) ? GAIN_MAX : level_ff;

   // circular read address: wp - delay, wrapped into the store
   always_comb begin
      rd_diff = {1'b0, wp_ff} - {1'b0, tap_delay[tap_ff]};
      if (rd_diff[ADDR_W]) begin
         rd_diff = rd_diff + (ADDR_W + 1)'(DELAY_DEPTH);
      end
      rd_addr = rd_diff[ADDR_W-1:0];
   end

   assign out_go = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      lane_ctrl.wr_en  = (state_ff == ST_WRITE);
      lane_ctrl.rd_en  = (state_ff == ST_TAPS);
      lane_ctrl.clear  = (state_ff == ST_WRITE);
      lane_ctrl.addr   = (state_ff == ST_WRITE) ? wp_ff : rd_addr;
      // fill count already includes the sample written this item
      lane_ctrl.hit    = ({1'b0, rd_addr} < fill_ff);
      lane_ctrl.weight = tap_weight[tap_ff];
      merge_ctrl.scale_en = (state_ff == ST_SCALE);
      merge_ctrl.load     = out_go;
   end

   smer_lane u_lane_l (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .neg       (tap_neg_l[tap_ff]),
      .wr_sample (left_ff),
      .acc       (acc_l)
   );

   smer_lane u_lane_r (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .neg       (tap_neg_r[tap_ff]),
      .wr_sample (right_ff),
      .acc       (acc_r)
   );

   smer_merge u_merge (
      .clock     (clock),
      .ctrl      (merge_ctrl),
      .level     (level_eff),
      .acc_left  (acc_l),
      .acc_right (acc_r),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out)
   );

   // sequencer, pointers, control registers and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         tap_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delays01_ff  <= '0;
         delays23_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            weight_ff[i] <= GAIN_ONE;
         end
         signs_ff     <= '0;
         level_ff     <= GAIN_ONE;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_DELAYS_01: delays01_ff  <= csr_data;
               CSR_DELAYS_23: delays23_ff  <= csr_data;
               CSR_WEIGHT_0:  weight_ff[0] <= csr_data[GAIN_W-1:0];
               CSR_WEIGHT_1:  weight_ff[1] <= csr_data[GAIN_W-1:0];
               CSR_WEIGHT_2:  weight_ff[2] <= csr_data[GAIN_W-1:0];
               CSR_WEIGHT_3:  weight_ff[3] <= csr_data[GAIN_W-1:0];
               CSR_SIGNS:     signs_ff     <= csr_data[7:0];
               CSR_LEVEL:     level_ff     <= csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end

         // a new result replaces one that leaves in the same cycle
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (fill_ff != FILL_W'(DELAY_DEPTH)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               tap_ff   <= '0;
               state_ff <= ST_TAPS;
            end
            ST_TAPS: begin
               if (tap_ff == TAP_W'(NUM_TAPS - 1)) begin
                  tap_ff   <= '0;
                  drain_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end else begin
                  tap_ff <= tap_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_go) begin
                  wp_ff        <= (wp_ff == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // sample capture on input transfer
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         left_ff  <= req_left_in;
         right_ff <= req_right_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

// ----- hw/rtl/smer_checker.sv -----
// Port-level checks for the stereo early-reflection block, bound to its top.
// Depends on smer_pkg and stereo_multitap_early_reflections.
`default_nettype none

module smer_checker
   import smer_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic signed [SAMPLE_W-1:0] req_left_in,
   input wire logic signed [SAMPLE_W-1:0] req_right_in,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [SAMPLE_W-1:0] rsp_left_out,
   input wire logic signed [SAMPLE_W-1:0] rsp_right_out,
   input wire logic                       csr_valid,
   input wire logic                       csr_ready,
   input wire logic [CSR_IDX_W-1:0]       csr_index,
   input wire logic [CSR_DATA_W-1:0]      csr_data
);

   // reset leaves no result pending and the input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out)
                                  && $stable(rsp_right_out))
      else $error("result changed while stalled");

   // the block is busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after a transfer");

   // a result never appears the cycle after an input transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early");

endmodule

bind stereo_multitap_early_reflections smer_checker u_smer_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for stereo_multitap_early_reflections: drives stereo sample pairs
// and register writes, predicts each reflection pair and checks every transfer.
// Depends on smer_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import smer_pkg::*;

   // pause longer than the block takes for one sample pair
   localparam int ITEM_CYCLES = NUM_TAPS + 6;
   localparam int SETTLE_CYCLES = ITEM_CYCLES + 4;
   // register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 4'd8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 4'd15;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_left_in  = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready    = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       csr_valid    = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index    = '0;
   logic [CSR_DATA_W-1:0]      csr_data     = '0;

   // predictor state: register copies, both history stores, write pointer
   logic [31:0]                delays01 = '0;
   logic [31:0]                delays23 = '0;
   logic [GAIN_W-1:0]          weight [NUM_TAPS];
   logic [7:0]                 signs = '0;
   logic [GAIN_W-1:0]          level = GAIN_ONE;
   logic signed [SAMPLE_W-1:0] hist_l [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] hist_r [DELAY_DEPTH];
   logic [ADDR_W-1:0]          wr_ptr = '0;

   stereo_pair_type expected_pairs [$];
   stereo_pair_type head_pair;
   int              fail_count = 0;
   bit              steady = 1'b0;   // set: neither side idles

   stereo_multitap_early_reflections dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // weights and level saturate at 4.0
   function automatic longint gain_clamp(logic [GAIN_W-1:0] g);
      return (g > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(g);
   endfunction

   // delay field of tap t, clamped to the store depth
   function automatic int unsigned tap_delay(int t);
      logic [31:0] word;
      int unsigned d;
      word = (t < 2) ? delays01 : delays23;
      d = (t % 2 == 1) ? word[31:16] : word[15:0];
      if (d > DELAY_DEPTH - 1) d = DELAY_DEPTH - 1;
      return d;
   endfunction

   // 43 fraction bits down to Q1.15: round half up, then saturate
   function automatic logic signed [SAMPLE_W-1:0] round_to_q15(longint scaled);
      longint q;
      q = (scaled + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return SAMPLE_W'(q);
   endfunction

   // store the pair, then sum the weighted taps of each side and scale
   function automatic stereo_pair_type reflect_pair(logic signed [SAMPLE_W-1:0] l,
                                                    logic signed [SAMPLE_W-1:0] r);
      longint acc_l, acc_r, w, pl, pr;
      int unsigned rd;
      int t;
      stereo_pair_type res;
      acc_l = 0;
      acc_r = 0;
      hist_l[wr_ptr] = l;
      hist_r[wr_ptr] = r;
      for (t = 0; t < NUM_TAPS; t++) begin
         rd = (int'(wr_ptr) + DELAY_DEPTH - tap_delay(t)) % DELAY_DEPTH;
         w  = gain_clamp(weight[t]);
         pl = longint'(hist_l[rd]) * w;
         pr = longint'(hist_r[rd]) * w;
         if (signs[t]) pl = -pl;
         if (signs[t + SIGN_R_OFS]) pr = -pr;
         acc_l += pl;
         acc_r += pr;
      end
      wr_ptr = wr_ptr + 1'b1;
      res.left  = round_to_q15(acc_l * gain_clamp(level));
      res.right = round_to_q15(acc_r * gain_clamp(level));
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2:    return SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return '0;
         1:       return GAIN_MAX;
         2:       return GAIN_W'($urandom_range(2 ** GAIN_W - 1, GAIN_MAX + 1));
         3:       return GAIN_W'($urandom_range(8192));
         4, 5:    return GAIN_W'($urandom_range(GAIN_MAX));
         default: return GAIN_W'($urandom_range(24576, 8192));
      endcase
   endfunction

   // near_taps keeps most delays short so that recent history dominates
   function automatic logic [DELAY_W-1:0] pick_delay(bit near_taps);
      if (near_taps && $urandom_range(3) != 0)
         return DELAY_W'($urandom_range(63));
      case ($urandom_range(5))
         0:       return '0;
         1:       return DELAY_W'($urandom_range(15));
         2:       return DELAY_W'($urandom_range(DELAY_DEPTH + 8, DELAY_DEPTH - 8));
         3:       return '1;
         default: return DELAY_W'($urandom);
      endcase
   endfunction

   // one sample pair transfer; the expectation is queued at acceptance
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
      while (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      do @(posedge clock); while (!req_ready);
      expected_pairs.push_back(reflect_pair(l, r));
   endtask

   // register write; the predictor copy follows at the transfer
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DELAYS_01: delays01  = data;
         CSR_DELAYS_23: delays23  = data;
         CSR_WEIGHT_0:  weight[0] = data[GAIN_W-1:0];
         CSR_WEIGHT_1:  weight[1] = data[GAIN_W-1:0];
         CSR_WEIGHT_2:  weight[2] = data[GAIN_W-1:0];
         CSR_WEIGHT_3:  weight[3] = data[GAIN_W-1:0];
         CSR_SIGNS:     signs     = data[7:0];
         CSR_LEVEL:     level     = data[GAIN_W-1:0];
         default: ;     // undecoded index: no effect
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let the block run dry before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // whole register set at random; upper data bits carry junk
   task automatic write_random_settings(input bit near_taps);
      logic [CSR_DATA_W-1:0] data;
      int i;
      write_csr(CSR_DELAYS_01, {pick_delay(near_taps), pick_delay(near_taps)});
      write_csr(CSR_DELAYS_23, {pick_delay(near_taps), pick_delay(near_taps)});
      for (i = 0; i < NUM_TAPS; i++) begin
         data = $urandom;
         data[GAIN_W-1:0] = pick_gain();
         write_csr(CSR_WEIGHT_0 + CSR_IDX_W'(i), data);
      end
      write_csr(CSR_SIGNS, $urandom);
      data = $urandom;
      data[GAIN_W-1:0] = pick_gain();
      write_csr(CSR_LEVEL, data);
      if ($urandom_range(2) == 0)
         write_csr(CSR_IDX_W'($urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO)), $urandom);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // reset settings: four taps at delay zero, all at unity, so the current
   // sample is summed four times and the extremes saturate
   task automatic test_reset_settings();
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(16'sd0, 16'sd0);
      send_pair(-16'sd1, 16'sd1);
      send_pair(16'sd1, -16'sd1);
      send_pair(16'sd8191, -16'sd8192);
      settle();
   endtask

   // extreme register values: clamped delays and gains, signs, zero level
   task automatic test_register_extremes();
      write_csr(CSR_DELAYS_01, {16'hFFFF, 16'd0});
      write_csr(CSR_DELAYS_23, {16'(DELAY_DEPTH), 16'(DELAY_DEPTH - 1)});
      write_csr(CSR_WEIGHT_0, 32'hFFFE_0000);
      write_csr(CSR_WEIGHT_1, 32'(GAIN_MAX));
      write_csr(CSR_WEIGHT_2, 32'h0001_FFFF);
      write_csr(CSR_WEIGHT_3, 32'h0000_0001);
      write_csr(CSR_SIGNS, 32'hFFFF_FFA5);
      write_csr(CSR_LEVEL, 32'(GAIN_MAX));
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(16'sd1234, -16'sd4321);
      settle();

      // undecoded indexes must leave every register alone
      write_csr(CSR_UNUSED_LO, 32'hFFFF_FFFF);
      write_csr(CSR_UNUSED_HI, 32'h0000_0000);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(16'sd300, 16'sd300);
      settle();

      // all taps negated at full level, then the level at zero
      write_csr(CSR_SIGNS, 32'h0000_00FF);
      write_csr(CSR_DELAYS_01, 32'h0001_0000);
      write_csr(CSR_DELAYS_23, 32'h0003_0002);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(16'sd100, -16'sd100);
      settle();
      write_csr(CSR_LEVEL, 32'h0000_0000);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      settle();

      // level above 4.0 acts as 4.0
      write_csr(CSR_LEVEL, 32'hAAAB_FFFF);
      send_pair(16'sd3, -16'sd3);
      send_pair(16'sd0, SAMPLE_MAX);
      send_pair(-16'sd7, 16'sd5);
      settle();
   endtask

   // a fresh random register set per phase with random traffic through it
   task automatic test_random_phases(input int phases, input int per_phase);
      int p, n;
      for (p = 0; p < phases; p++) begin
         write_random_settings(p % 2 == 0);
         for (n = 0; n < per_phase; n++)
            send_pair(pick_sample(), pick_sample());
         settle();
      end
   endtask

   // back-to-back transfers on both sides, no idling anywhere
   task automatic test_steady_stream(input int count);
      int n;
      steady = 1'b1;
      write_random_settings(1'b1);
      for (n = 0; n < count; n++)
         send_pair(pick_sample(), pick_sample());
      settle();
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // receiver holds rsp_ready low at random, about 9 percent of the time, unless a steady stretch is on
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 9);
   end

   // every result transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            $error("unexpected result: left_out %0d right_out %0d",
                   rsp_left_out, rsp_right_out);
            fail_count++;
         end else begin
            head_pair = expected_pairs.pop_front();
            if (rsp_left_out !== head_pair.left) begin
               $error("left_out: expected %0d, actual %0d", head_pair.left, rsp_left_out);
               fail_count++;
            end
            if (rsp_right_out !== head_pair.right) begin
               $error("right_out: expected %0d, actual %0d", head_pair.right, rsp_right_out);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      foreach (hist_l[i]) begin
         hist_l[i] = '0;
         hist_r[i] = '0;
      end
      foreach (weight[i]) weight[i] = GAIN_ONE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_register_extremes();
      test_random_phases(7, 130);
      test_steady_stream(220);

      if (fail_count == 0 && expected_pairs.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
